// ===== rtl/b64sc_pkg.sv =====
package b64sc_pkg;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // decoded character classes beyond the 6-bit alphabet values
  localparam logic [6:0] CV_PAD = 7'd64;
  localparam logic [6:0] CV_BAD = 7'd65;

  // group positions
  localparam logic [1:0] GP_0 = 2'd0;
  localparam logic [1:0] GP_1 = 2'd1;
  localparam logic [1:0] GP_2 = 2'd2;
  localparam logic [1:0] GP_3 = 2'd3;

  // one queued work entry: up to four results from one accepted item
  typedef struct packed {
    logic [3:0][7:0] chars;  // result bytes, index 0 goes out first
    logic [1:0]      cnt;    // number of results minus one
    logic            last;   // final result of the entry ends the message
    logic            bad;    // bad-character flag for every result of the entry
  } b64sc_entry_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else if (c == PAD_CHAR) begin
      r = CV_PAD;
    end else begin
      r = CV_BAD;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64sc_front.sv =====
module b64sc_front
  import b64sc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_mode,
  input  logic         acc,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  output logic         ent_valid,
  output b64sc_entry_t ent
);

  logic       mode_r;
  logic [1:0] gp_r, gp_nxt;
  logic [7:0] held_r, held_nxt;
  logic       pad_r, pad_nxt;

  logic [6:0] cv;
  logic [5:0] v6;
  logic       bad_now;
  logic       pend;
  logic       has;

  assign cv      = char_value(in_byte);
  assign bad_now = (cv == CV_BAD);
  assign v6      = bad_now ? 6'd0 : cv[5:0];
  assign pend    = held_r[7];

  always_comb begin
    gp_nxt    = gp_r;
    held_nxt  = held_r;
    pad_nxt   = pad_r;
    ent       = '0;
    ent.last  = in_last;
    has       = 1'b0;
    if (mode_r == MODE_ENC) begin
      has = 1'b1;
      unique case (gp_r)
        GP_1: begin
          ent.chars[0] = enc_char({held_r[1:0], in_byte[7:4]});
          held_nxt     = {4'd0, in_byte[3:0]};
          gp_nxt       = GP_2;
          if (in_last) begin
            ent.chars[1] = enc_char({in_byte[3:0], 2'b00});
            ent.chars[2] = PAD_CHAR;
            ent.cnt      = 2'd2;
          end
        end
        GP_2: begin
          ent.chars[0] = enc_char({held_r[3:0], in_byte[7:6]});
          ent.chars[1] = enc_char(in_byte[5:0]);
          ent.cnt      = 2'd1;
          held_nxt     = '0;
          gp_nxt       = GP_0;
        end
        default: begin
          // position 3 cannot arise when encoding and acts as position 0
          ent.chars[0] = enc_char(in_byte[7:2]);
          held_nxt     = {6'd0, in_byte[1:0]};
          gp_nxt       = GP_1;
          if (in_last) begin
            ent.chars[1] = enc_char({in_byte[1:0], 4'd0});
            ent.chars[2] = PAD_CHAR;
            ent.chars[3] = PAD_CHAR;
            ent.cnt      = 2'd3;
          end
        end
      endcase
    end else begin
      if (!pad_r) begin
        if (cv == CV_PAD) begin
          pad_nxt = 1'b1;
        end else begin
          ent.bad = pend | bad_now;
          unique case (gp_r)
            GP_0: begin
              held_nxt = {bad_now, 1'b0, v6};
              gp_nxt   = GP_1;
            end
            GP_1: begin
              ent.chars[0] = {held_r[5:0], v6[5:4]};
              has          = 1'b1;
              held_nxt     = {bad_now, 3'd0, v6[3:0]};
              gp_nxt       = GP_2;
            end
            GP_2: begin
              ent.chars[0] = {held_r[3:0], v6[5:2]};
              has          = 1'b1;
              held_nxt     = {bad_now, 5'd0, v6[1:0]};
              gp_nxt       = GP_3;
            end
            default: begin
              ent.chars[0] = {held_r[1:0], v6};
              has          = 1'b1;
              held_nxt     = '0;
              gp_nxt       = GP_0;
            end
          endcase
        end
      end
      // terminator when the last item yields no byte
      if (in_last && !has) begin
        ent.chars[0] = '0;
        ent.bad      = pend | (bad_now & ~pad_r & (cv != CV_PAD));
        has          = 1'b1;
      end
    end
    if (in_last) begin
      gp_nxt   = GP_0;
      held_nxt = '0;
      pad_nxt  = 1'b0;
    end
  end

  assign ent_valid = acc & has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      gp_r   <= GP_0;
      held_r <= '0;
      pad_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_mode;
      gp_r   <= GP_0;
      held_r <= '0;
      pad_r  <= 1'b0;
    end else if (acc) begin
      gp_r   <= gp_nxt;
      held_r <= held_nxt;
      pad_r  <= pad_nxt;
    end
  end

endmodule

// ===== rtl/b64sc_queue.sv =====
module b64sc_queue
  import b64sc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  b64sc_entry_t wdata,
  input  logic         rd,
  output b64sc_entry_t rdata,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64sc_entry_t   mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem_r[rp_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= bump(wp_r);
      end
      if (do_rd) begin
        rp_r <= bump(rp_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64sc_back.sv =====
module b64sc_back
  import b64sc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  b64sc_entry_t q_head,
  output logic         q_rd,
  input  logic         pop,
  output logic         empty,
  output logic [7:0]   out_byte,
  output logic         out_last,
  output logic         out_bad_char
);

  b64sc_entry_t cur_r;
  logic         val_r;
  logic [1:0]   idx_r;
  logic         at_end;
  logic         take;

  assign at_end = (idx_r == cur_r.cnt);
  assign take   = val_r & pop;
  assign q_rd   = ~q_empty & (~val_r | (take & at_end));

  assign empty        = ~val_r;
  assign out_byte     = cur_r.chars[idx_r];
  assign out_last     = cur_r.last & at_end;
  assign out_bad_char = cur_r.bad;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      idx_r <= '0;
    end else if (q_rd) begin
      val_r <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (at_end) begin
        val_r <= 1'b0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/base64_stream_codec_top.sv =====
// streaming base64 codec (standard alphabet, '=' padding). cfg_mode selects encode
// (bytes in, characters out) or decode (characters in, bytes out); writing it clears
// the group state and must happen only while the block is idle. both sides behave
// as queues: an item goes in when push is high and full is low, and a result leaves
// when pop is high and empty is low. the front end takes one item every cycle while
// its queue has room and turns it into zero to four results in a single entry; those
// entries wait in a DEPTH-entry queue and the back end sends one result per cycle
// while pop is high. so an encoder sustains four characters per three bytes, a
// flush on the last byte yields up to four characters, and a decoder runs at one
// character per cycle; the one-result-per-cycle output port sets the encode rate.
// each accepted item's results are registered in the entry queue and then in the back
// end's current entry. decode flags characters outside the alphabet on out_bad_char
// and treats them as zero; after a '=' the rest of the message is dropped, and a last
// item that yields no byte produces a single zero terminator marked out_last.
module base64_stream_codec_top
  import b64sc_pkg::*;
#(
  parameter int DEPTH = 4  // entry queue depth, 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_mode,
  // item input
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_bad_char
);

  b64sc_entry_t ent, q_head;
  logic         ent_valid;
  logic         acc;
  logic         q_rd, q_empty;

  // an item is taken whenever the entry queue has room
  assign acc = push & ~full;

  // front: mode register, group state and per-item result generation
  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_mode  (cfg_mode),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  // short queue decoupling item intake from result delivery
  b64sc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ent_valid),
    .wdata (ent),
    .rd    (q_rd),
    .rdata (q_head),
    .full  (full),
    .empty (q_empty)
  );

  // back: holds the current entry and steps through its results
  b64sc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_bad_char (out_bad_char)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import b64sc_pkg::*;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_result_t;

  // tracks the codec group state and holds the results still due from the block
  class b64_tracker;
    string         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic          coding_mode = MODE_ENC;
    logic [1:0]    grp = GP_0;
    logic [7:0]    held = 8'h00;
    logic          pad_seen = 1'b0;
    codec_result_t due_results[$];
    int            errors = 0;

    function void clear_group();
      grp = GP_0;
      held = 8'h00;
      pad_seen = 1'b0;
    endfunction

    function void set_mode(logic m);
      coding_mode = m;
      clear_group();
    endfunction

    function void add(logic [7:0] d, logic l, logic b);
      codec_result_t r;
      r.data = d;
      r.last = l;
      r.bad = b;
      due_results = {due_results, r};
    endfunction

    function logic [7:0] to_char(logic [5:0] v);
      return alphabet[v];
    endfunction

    // 6-bit value of a character, or the pad / invalid class
    function logic [6:0] sextet_of(logic [7:0] c);
      int i;
      for (i = 0; i < 64; i++) begin
        if (alphabet[i] == c) return 7'(i);
      end
      if (c == PAD_CHAR) return CV_PAD;
      return CV_BAD;
    endfunction

    // works out the results of one accepted item
    function void code_item(logic [7:0] b, logic l);
      logic [7:0] h;
      logic       pend;
      logic       bad_now;
      logic       made;
      logic [6:0] v;
      h = held;
      if (coding_mode == MODE_ENC) begin
        case (grp)
          GP_1: begin
            add(to_char({h[1:0], b[7:4]}), 1'b0, 1'b0);
            held = {4'h0, b[3:0]};
            grp = GP_2;
            if (l) begin
              add(to_char({b[3:0], 2'b00}), 1'b0, 1'b0);
              add(PAD_CHAR, 1'b1, 1'b0);
            end
          end
          GP_2: begin
            add(to_char({h[3:0], b[7:6]}), 1'b0, 1'b0);
            add(to_char(b[5:0]), l, 1'b0);
            held = 8'h00;
            grp = GP_0;
          end
          default: begin
            add(to_char(b[7:2]), 1'b0, 1'b0);
            held = {6'h00, b[1:0]};
            grp = GP_1;
            if (l) begin
              add(to_char({b[1:0], 4'h0}), 1'b0, 1'b0);
              add(PAD_CHAR, 1'b0, 1'b0);
              add(PAD_CHAR, 1'b1, 1'b0);
            end
          end
        endcase
      end else begin
        pend = h[7];
        bad_now = 1'b0;
        made = 1'b0;
        if (!pad_seen) begin
          v = sextet_of(b);
          if (v == CV_PAD) begin
            pad_seen = 1'b1;
          end else begin
            if (v == CV_BAD) begin
              bad_now = 1'b1;
              v = 7'd0;
            end
            made = (grp != GP_0);
            case (grp)
              GP_0: begin
                held = {bad_now, 1'b0, v[5:0]};
                grp = GP_1;
              end
              GP_1: begin
                add({h[5:0], v[5:4]}, 1'b0, pend | bad_now);
                held = {bad_now, 3'b000, v[3:0]};
                grp = GP_2;
              end
              GP_2: begin
                add({h[3:0], v[5:2]}, 1'b0, pend | bad_now);
                held = {bad_now, 5'b00000, v[1:0]};
                grp = GP_3;
              end
              default: begin
                add({h[1:0], v[5:0]}, 1'b0, pend | bad_now);
                held = 8'h00;
                grp = GP_0;
              end
            endcase
          end
        end
        if (l) begin
          if (made) due_results[due_results.size() - 1].last = 1'b1;
          else add(8'h00, 1'b1, pend | bad_now);
        end
      end
      if (l) clear_group();
    endfunction

    function void report(string what, codec_result_t e, codec_result_t g);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
                 what, e.data, e.last, e.bad, g.data, g.last, g.bad);
      end
    endfunction

    // compares one result leaving the block with the oldest one due
    function void take_result(codec_result_t got);
      codec_result_t exp_r;
      if (due_results.size() == 0) begin
        exp_r = '0;
        report("unexpected result", exp_r, got);
      end else begin
        exp_r = due_results.pop_front();
        if (exp_r != got) report("mismatch", exp_r, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_mode = MODE_ENC;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_bad_char;

  b64_tracker tracker = new;
  logic [7:0] msg[$];      // characters or bytes of the message being built
  int         items_sent = 0;
  logic       idle_on = 1'b1;  // random gaps on both sides, off near the end

  localparam int ITEM_TARGET = 240;

  always #1 clk = ~clk;

  base64_stream_codec_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_mode    (cfg_mode),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_bad_char(out_bad_char)
  );

  // result side: pop driven at the falling edge, stalls in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // a result is taken at the rising edge where pop is high and empty is low
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      tracker.take_result({out_byte, out_last, out_bad_char});
    end
  end

  // offers one item, sometimes after a random gap, and waits until it is taken
  task send_item(logic [7:0] b, logic l);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_byte = b;
    in_last = l;
    @(posedge clk);
    while (full) @(posedge clk);
    // full was low at this edge, so the item went in
    tracker.code_item(b, l);
    items_sent++;
  endtask

  // sends the built message, in_last on its final item
  task send_message();
    int i;
    for (i = 0; i < msg.size(); i++) begin
      send_item(msg[i], i == msg.size() - 1);
    end
  endtask

  task load_text(string s);
    int i;
    msg.delete();
    for (i = 0; i < s.len(); i++) msg = {msg, s[i]};
  endtask

  // lets all due results drain, then waits on for items that make no result
  task wait_quiet();
    @(negedge clk);
    push = 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mode write only while the block is quiet; it clears the group state
  task write_mode(logic m);
    wait_quiet();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_mode = m;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_mode(m);
  endtask

  // random raw bytes, mostly short messages
  task build_encode_message();
    int n;
    int i;
    msg.delete();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
    for (i = 0; i < n; i++) msg = {msg, 8'($urandom_range(0, 255))};
  endtask

  // mostly well-formed text with random content, some broken or pure noise
  task build_decode_message();
    int kind;
    int groups;
    int i;
    int n;
    msg.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // pure noise
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) msg = {msg, 8'($urandom_range(0, 255))};
    end else begin
      groups = $urandom_range(1, 3);
      for (i = 0; i < 4 * groups; i++) begin
        msg = {msg, tracker.alphabet[$urandom_range(0, 63)]};
      end
      // optional padding in the final group
      case ($urandom_range(0, 2))
        1: msg[msg.size() - 1] = PAD_CHAR;
        2: begin
          msg[msg.size() - 1] = PAD_CHAR;
          msg[msg.size() - 2] = PAD_CHAR;
        end
        default: ;
      endcase
      if (kind == 1) begin
        // one character outside the alphabet, or anything at all
        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 2) begin
        // cut short anywhere
        n = $urandom_range(1, msg.size());
        while (msg.size() > n) void'(msg.pop_back());
      end else if (kind == 3) begin
        // trailing junk, dropped if it follows a pad
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) msg = {msg, 8'($urandom_range(0, 255))};
      end
    end
  endtask

  initial begin
    logic m;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: encode after reset, full group, one byte and two byte flushes
    load_text("Man");
    send_message();
    msg = '{8'hFF};
    send_message();
    msg = '{8'h00, 8'hFF};
    send_message();
    // message left open: the mode write must drop the partial group
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    write_mode(MODE_DEC);
    // directed decode: full group, double pad, invalid lead char,
    // lone invalid last item, items ignored after a pad
    load_text("TWFu");
    send_message();
    load_text("QQ==");
    send_message();
    load_text("*BCD");
    send_message();
    msg = '{8'h00};
    send_message();
    load_text("A=x");
    msg = {msg, 8'hFF};
    send_message();

    // random phases, each under a freshly written mode
    while (items_sent < ITEM_TARGET) begin
      m = $urandom_range(0, 1);
      write_mode(m);
      repeat ($urandom_range(3, 8)) begin
        if (items_sent >= ITEM_TARGET - 60) idle_on = 1'b0;
        if (m == MODE_ENC) build_encode_message();
        else build_decode_message();
        send_message();
      end
    end

    wait_quiet();
    repeat (12) @(posedge clk);
    if (tracker.due_results.size() != 0) begin
      $display("%0d results never arrived", tracker.due_results.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run time guard
  initial begin
    #1000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
